FILE: sv/rbpe_pkg.sv
// Shared types and constants of the run-length byte pair encoder.
`default_nettype none
package rbpe_pkg;

   localparam int unsigned ByteWidth     = 8;
   localparam int unsigned CountWidth    = 16;
   localparam int unsigned CsrIndexWidth = 1;
   localparam int unsigned QueueDepth    = 2;
   localparam int unsigned MaxBytes      = 6;
   localparam int unsigned StepWidth     = 3;

   localparam logic [ByteWidth-1:0] RunCap     = 8'd255;
   localparam logic [ByteWidth-1:0] ValueBias  = 8'd128;

   // register indexes of the configuration port
   localparam logic [CsrIndexWidth-1:0] RegRowCount    = 1'd0;
   localparam logic [CsrIndexWidth-1:0] RegColumnCount = 1'd1;

   // one classified input item, as handed from the front to the back
   typedef struct packed {
      logic                  hdr;       // send the four header bytes first
      logic [CountWidth-1:0] rows;
      logic [CountWidth-1:0] cols;
      logic                  run_emit;  // send a closed run
      logic [ByteWidth-1:0]  run_cnt;
      logic [ByteWidth-1:0]  run_byte;  // biased value
      logic                  fin;       // send the flushed run, end of frame
      logic [ByteWidth-1:0]  fin_cnt;
      logic [ByteWidth-1:0]  fin_byte;  // biased value
   } cmd_type;

endpackage
`default_nettype wire

FILE: sv/rbpe_ifs.sv
// Channel interfaces: input elements, output bytes and configuration writes.
`default_nettype none
interface rbpe_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [rbpe_pkg::ByteWidth-1:0] sample_value;
   logic                                frame_end;
   modport source (output valid, output sample_value, output frame_end, input ready);
   modport sink   (input valid, input sample_value, input frame_end, output ready);
endinterface

interface rbpe_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [rbpe_pkg::ByteWidth-1:0] out_byte;
   logic                         burst_end;
   logic                         stream_end;
   modport source (output valid, output out_byte, output burst_end, output stream_end,
                   input ready);
   modport sink   (input valid, input out_byte, input burst_end, input stream_end,
                   output ready);
endinterface

interface rbpe_csr_if;
   logic                             valid;
   logic                             ready;
   logic [rbpe_pkg::CsrIndexWidth-1:0] index;
   logic [rbpe_pkg::CountWidth-1:0]    data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: sv/rle_byte_pair_encoder.sv
// Top level of the run-length byte pair encoder.
//
//   channel  dir  handshake     payload
//   req_ch   in   valid/ready   sample_value[7:0] signed, frame_end
//   rsp_ch   out  valid/ready   out_byte[7:0], burst_end, stream_end
//   csr_ch   in   valid/ready   index[0] (0 rows, 1 columns), data[15:0]
//
// The back sends one byte per cycle while rsp_ch is ready, and an element
// makes 0, 2, 4 or 6 bytes; a run change with no header or frame end makes 2.
// Reset is synchronous and clears run state, the queue and the output valid flag.
// A stalled rsp_ch holds its byte; the front keeps taking elements until the
// two-entry queue fills, then drops req_ch ready.
`default_nettype none
module rle_byte_pair_encoder (
   input wire logic   clock,
   input wire logic   reset,
   rbpe_req_if.sink   req_ch,
   rbpe_rsp_if.source rsp_ch,
   rbpe_csr_if.sink   csr_ch
);

   rbpe_pkg::cmd_type push_data;
   rbpe_pkg::cmd_type pop_data;
   logic              push;
   logic              pop;
   logic              full;
   logic              not_empty;

   // classify each element transaction and track the open run
   rbpe_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_ch),
      .csr    (csr_ch),
      .q_full (full),
      .q_data (push_data),
      .q_push (push)
   );

   // decouple classification from byte output
   rbpe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .not_empty (not_empty)
   );

   // advance one output byte per cycle while rsp_ch takes it
   rbpe_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (not_empty),
      .q_data  (pop_data),
      .q_pop   (pop),
      .rsp     (rsp_ch)
   );

endmodule
`default_nettype wire

FILE: sv/rbpe_front.sv
// Front part: configuration registers, run tracking and item classification.
`default_nettype none
module rbpe_front (
   input  wire logic          clock,
   input  wire logic          reset,
   rbpe_req_if.sink           req,
   rbpe_csr_if.sink           csr,
   input  wire logic          q_full,
   output rbpe_pkg::cmd_type  q_data,
   output logic               q_push
);

   logic [rbpe_pkg::CountWidth-1:0] rows_ff, rows_in;
   logic [rbpe_pkg::CountWidth-1:0] cols_ff, cols_in;
   logic [rbpe_pkg::ByteWidth-1:0]  run_value_ff, run_value_in;
   logic [rbpe_pkg::ByteWidth-1:0]  run_length_ff, run_length_in;
   logic                            started_ff, started_in;
   logic                            accept;
   logic [rbpe_pkg::ByteWidth-1:0]  sample;
   rbpe_pkg::cmd_type               cmd;

   assign csr.ready = 1'b1;
   assign req.ready = !q_full;
   assign accept    = req.valid && req.ready;
   assign sample    = req.sample_value;

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr.valid) begin
         case (csr.index)
            rbpe_pkg::RegRowCount:    rows_in = csr.data;
            rbpe_pkg::RegColumnCount: cols_in = csr.data;
            default: ;
         endcase
      end
   end

   // classify the element against the open run
   always_comb begin
      run_value_in  = run_value_ff;
      run_length_in = run_length_ff;
      started_in    = started_ff;
      cmd           = '0;
      cmd.rows      = rows_ff;
      cmd.cols      = cols_ff;
      cmd.run_cnt   = run_length_ff;
      cmd.run_byte  = run_value_ff + rbpe_pkg::ValueBias;
      if (!started_ff) begin
         cmd.hdr       = 1'b1;
         run_value_in  = sample;
         run_length_in = 8'd1;
         started_in    = 1'b1;
      end else if (sample == run_value_ff) begin
         if (run_length_ff == rbpe_pkg::RunCap) begin
            cmd.run_emit  = 1'b1;
            run_length_in = 8'd1;
         end else begin
            run_length_in = run_length_ff + 8'd1;
         end
      end else begin
         cmd.run_emit  = 1'b1;
         run_value_in  = sample;
         run_length_in = 8'd1;
      end
      if (req.frame_end) begin
         cmd.fin    = 1'b1;
         started_in = 1'b0;
      end
      cmd.fin_cnt  = run_length_in;
      cmd.fin_byte = run_value_in + rbpe_pkg::ValueBias;
   end

   assign q_data = cmd;
   assign q_push = accept && (cmd.hdr || cmd.run_emit || cmd.fin);

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff       <= '0;
         cols_ff       <= '0;
         run_value_ff  <= '0;
         run_length_ff <= '0;
         started_ff    <= 1'b0;
      end else begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
         if (accept) begin
            run_value_ff  <= run_value_in;
            run_length_ff <= run_length_in;
            started_ff    <= started_in;
         end
      end
   end

endmodule
`default_nettype wire

FILE: sv/rbpe_queue.sv
// Short queue of classified items between front and back.
`default_nettype none
module rbpe_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire rbpe_pkg::cmd_type  push_data,
   output logic                    full,
   input  wire logic               pop,
   output rbpe_pkg::cmd_type       pop_data,
   output logic                    not_empty
);

   localparam int unsigned PtrWidth = (rbpe_pkg::QueueDepth > 1) ?
                                      $clog2(rbpe_pkg::QueueDepth) : 1;
   localparam int unsigned CntWidth = $clog2(rbpe_pkg::QueueDepth + 1);
   localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(rbpe_pkg::QueueDepth - 1);
   localparam logic [CntWidth-1:0] FullCnt = CntWidth'(rbpe_pkg::QueueDepth);

   rbpe_pkg::cmd_type   entry_ff [rbpe_pkg::QueueDepth];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;

   assign full      = (cnt_ff == FullCnt);
   assign not_empty = (cnt_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("queue read while empty");

endmodule
`default_nettype wire

FILE: sv/rbpe_back.sv
// Back part: expands one classified item into its output bytes.
`default_nettype none
module rbpe_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_valid,
   input  wire rbpe_pkg::cmd_type  q_data,
   output logic                    q_pop,
   rbpe_rsp_if.source              rsp
);

   localparam int unsigned BW = rbpe_pkg::ByteWidth;
   localparam int unsigned SW = rbpe_pkg::StepWidth;

   logic [BW-1:0] bytes_ff [rbpe_pkg::MaxBytes];
   logic [BW-1:0] bytes_in [rbpe_pkg::MaxBytes];
   logic [SW-1:0] cnt_ff, cnt_in;
   logic [SW-1:0] step_ff, step_in;
   logic          fin_ff;
   logic          cur_valid_ff, cur_valid_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [BW-1:0] rsp_byte_ff;
   logic          rsp_burst_ff;
   logic          rsp_stream_ff;
   logic          out_free;
   logic          fire;
   logic          last_byte;

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign fire      = cur_valid_ff && out_free;
   assign last_byte = (step_ff == cnt_ff - 3'd1);
   assign q_pop     = q_valid && (!cur_valid_ff || (fire && last_byte));

   // lay out the byte sequence of the item at the queue head
   always_comb begin
      for (int i = 0; i < rbpe_pkg::MaxBytes; i++) begin
         bytes_in[i] = '0;
      end
      cnt_in = 3'd2;
      if (q_data.hdr) begin
         bytes_in[0] = q_data.rows[15:8];
         bytes_in[1] = q_data.rows[7:0];
         bytes_in[2] = q_data.cols[15:8];
         bytes_in[3] = q_data.cols[7:0];
         bytes_in[4] = q_data.fin_cnt;
         bytes_in[5] = q_data.fin_byte;
         cnt_in      = q_data.fin ? 3'd6 : 3'd4;
      end else if (q_data.run_emit) begin
         bytes_in[0] = q_data.run_cnt;
         bytes_in[1] = q_data.run_byte;
         bytes_in[2] = q_data.fin_cnt;
         bytes_in[3] = q_data.fin_byte;
         cnt_in      = q_data.fin ? 3'd4 : 3'd2;
      end else begin
         bytes_in[0] = q_data.fin_cnt;
         bytes_in[1] = q_data.fin_byte;
         cnt_in      = 3'd2;
      end
   end

   always_comb begin
      cur_valid_in = cur_valid_ff;
      step_in      = step_ff;
      if (q_pop) begin
         cur_valid_in = 1'b1;
         step_in      = '0;
      end else if (fire) begin
         if (last_byte) begin
            cur_valid_in = 1'b0;
         end
         step_in = step_ff + 3'd1;
      end
      rsp_valid_in = fire ? 1'b1 : (out_free ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         bytes_ff <= bytes_in;
         cnt_ff   <= cnt_in;
         fin_ff   <= q_data.fin;
      end
      if (fire) begin
         rsp_byte_ff   <= bytes_ff[step_ff];
         rsp_burst_ff  <= last_byte;
         rsp_stream_ff <= last_byte && fin_ff;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.out_byte   = rsp_byte_ff;
   assign rsp.burst_end  = rsp_burst_ff;
   assign rsp.stream_end = rsp_stream_ff;

   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> (step_ff < cnt_ff))
      else $error("byte step beyond item length");
   a_stream_ends_burst: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stream_ff) |-> rsp_burst_ff)
      else $error("frame end not on last byte of a transaction burst");
   a_load_only_when_done: assert property (@(posedge clock) disable iff (reset)
      (q_pop && cur_valid_ff) |-> (fire && last_byte))
      else $error("item replaced before all bytes sent");

endmodule
`default_nettype wire

FILE: verif/tb_top.sv
// Self-checking testbench of the run-length byte pair encoder.
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // Run length limits: the slowest correct run stays far below this.
   localparam int CycleLimit   = 400000;
   // Cycles to let the encoder settle once every expected byte has come.
   localparam int SettleCycles = 8;
   localparam int RandomItems  = 40;

   // One expected output byte with its side flags.
   typedef struct packed {
      logic [rbpe_pkg::ByteWidth-1:0] out_byte;
      logic                           burst_end;
      logic                           stream_end;
   } enc_byte_type;

   logic clock = 1'b0;
   logic reset;

   rbpe_req_if req_if();
   rbpe_rsp_if rsp_if();
   rbpe_csr_if csr_if();

   rle_byte_pair_encoder uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   // 4 ns period clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Shadow state of the encoder: dimension registers and the open run.
   // Only the stimulus process writes these.
   // ---------------------------------------------------------------------
   logic [rbpe_pkg::CountWidth-1:0] dims_rows;
   logic [rbpe_pkg::CountWidth-1:0] dims_cols;
   logic [rbpe_pkg::ByteWidth-1:0]  run_val;
   logic [rbpe_pkg::ByteWidth-1:0]  run_len;
   logic                            frame_open;

   // Bytes the encoder still owes us, oldest first.
   enc_byte_type pending_bytes[$];

   int error_count = 0;
   int cycle_count = 0;

   // Idle bounds for both sides, redrawn per test phase.
   int req_gap_max = 0;
   int rsp_gap_max = 0;

   // Long receiver hold-off request: bump hold_seq to start one.
   int hold_seq = 0;
   int hold_len = 0;

   // ---------------------------------------------------------------------
   // Predictor: advance the shadow state by one element and queue the bytes
   // that element must produce. burst_end goes on the last byte of the burst.
   // ---------------------------------------------------------------------
   function automatic void add_byte(ref enc_byte_type burst[$],
                                    input logic [rbpe_pkg::ByteWidth-1:0] b,
                                    input logic last_of_frame);
      enc_byte_type e;
      e.out_byte   = b;
      e.burst_end  = 1'b0;
      e.stream_end = last_of_frame;
      burst = {burst, e};
   endfunction

   function automatic void add_run(ref enc_byte_type burst[$], input logic last_of_frame);
      logic [rbpe_pkg::ByteWidth-1:0] biased;
      biased = run_val + rbpe_pkg::ValueBias;
      add_byte(burst, run_len, 1'b0);
      add_byte(burst, biased, last_of_frame);
   endfunction

   function automatic void encode_sample(input logic [rbpe_pkg::ByteWidth-1:0] s,
                                         input logic last);
      enc_byte_type burst[$];
      enc_byte_type e;
      if (!frame_open) begin
         // first element of a frame: header, high byte first
         add_byte(burst, dims_rows[15:8], 1'b0);
         add_byte(burst, dims_rows[7:0], 1'b0);
         add_byte(burst, dims_cols[15:8], 1'b0);
         add_byte(burst, dims_cols[7:0], 1'b0);
         run_val    = s;
         run_len    = 8'd1;
         frame_open = 1'b1;
      end else if (s == run_val) begin
         if (run_len == rbpe_pkg::RunCap) begin
            // full run: send it and start a fresh one of the same value
            add_run(burst, 1'b0);
            run_len = 8'd1;
         end else begin
            run_len = run_len + 8'd1;
         end
      end else begin
         add_run(burst, 1'b0);
         run_val = s;
         run_len = 8'd1;
      end
      if (last) begin
         // flush the open run and re-arm for the next header
         add_run(burst, 1'b1);
         frame_open = 1'b0;
      end
      for (int i = 0; i < burst.size(); i++) begin
         e = burst[i];
         e.burst_end = (i == burst.size() - 1);
         pending_bytes = {pending_bytes, e};
      end
   endfunction

   // ---------------------------------------------------------------------
   // Receiver: per byte draw a hold-off bounded by rsp_gap_max; a pending
   // long hold request overrides the draw. Counts cycles in its own process.
   // ---------------------------------------------------------------------
   initial begin : rsp_receiver
      int rsp_wait;
      int hold_seen;
      int g;
      rsp_wait  = 0;
      hold_seen = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_if.ready <= 1'b0;
            rsp_wait = 0;
         end else if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            rsp_wait  = hold_len;
            rsp_if.ready <= 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_wait = rsp_wait - 1;
            rsp_if.ready <= 1'b0;
         end else if (!rsp_if.ready) begin
            rsp_if.ready <= 1'b1;
         end else if (rsp_if.valid) begin
            // a transaction happens at this edge: draw the next hold-off
            g = $urandom_range(0, rsp_gap_max);
            if (g > 0) begin
               rsp_if.ready <= 1'b0;
               rsp_wait = g - 1;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Checker: compare every output transaction with the oldest expectation.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : check_bytes
      enc_byte_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_bytes.size() == 0) begin
            $display("%0t ns: unexpected byte: expected none, actual byte %02h burst %b end %b",
                     $time, rsp_if.out_byte, rsp_if.burst_end, rsp_if.stream_end);
            error_count++;
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_if.out_byte !== want.out_byte) begin
               $display("%0t ns: out_byte mismatch: expected %02h, actual %02h",
                        $time, want.out_byte, rsp_if.out_byte);
               error_count++;
            end
            if (rsp_if.burst_end !== want.burst_end) begin
               $display("%0t ns: burst_end mismatch: expected %b, actual %b",
                        $time, want.burst_end, rsp_if.burst_end);
               error_count++;
            end
            if (rsp_if.stream_end !== want.stream_end) begin
               $display("%0t ns: stream_end mismatch: expected %b, actual %b",
                        $time, want.stream_end, rsp_if.stream_end);
               error_count++;
            end
         end
      end
   end

   // Watchdog: give up if the run hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Driver tasks. Each one starts and ends right after a rising edge.
   // ---------------------------------------------------------------------

   // Offer one element; valid stays high on return so back-to-back
   // transactions need no extra assignment in the same step.
   task automatic send_sample(input logic [rbpe_pkg::ByteWidth-1:0] s, input logic last);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.sample_value <= s;
      req_if.frame_end    <= last;
      do @(posedge clock); while (!req_if.ready);
      encode_sample(s, last);
   endtask

   // Drop valid, wait until every expected byte has arrived, then settle.
   task automatic drain_encoder();
      req_if.valid <= 1'b0;
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // One register write transaction; valid stays high on return.
   task automatic write_dims_reg(input logic [rbpe_pkg::CsrIndexWidth-1:0] idx,
                                 input logic [rbpe_pkg::CountWidth-1:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
      if (idx == rbpe_pkg::RegRowCount) dims_rows = value;
      else dims_cols = value;
   endtask

   // Call only while the encoder is idle.
   task automatic set_dims(input logic [rbpe_pkg::CountWidth-1:0] rows,
                           input logic [rbpe_pkg::CountWidth-1:0] cols);
      write_dims_reg(rbpe_pkg::RegRowCount, rows);
      write_dims_reg(rbpe_pkg::RegColumnCount, cols);
      csr_if.valid <= 1'b0;
   endtask

   task automatic set_gaps(input int req_max, input int rsp_max);
      req_gap_max = req_max;
      rsp_gap_max = rsp_max;
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // One-element frames: reset header of zeros, both header extremes, then a mixed pattern.
   task automatic test_single_element_frames();
      set_gaps(0, 0);
      send_sample(8'h80, 1'b1);
      drain_encoder();
      set_dims(16'hFFFF, 16'h0000);
      send_sample(8'h7F, 1'b1);
      drain_encoder();
      set_dims(16'h0000, 16'hFFFF);
      send_sample(8'h00, 1'b1);
      drain_encoder();
      set_dims(16'hA55A, 16'h5AA5);
      send_sample(8'hFF, 1'b1);
      drain_encoder();
   endtask

   // Runs of various lengths, value changes at both extremes, frame end on a
   // repeated value and on a new value.
   task automatic test_run_changes();
      logic [rbpe_pkg::ByteWidth-1:0] vals[] = '{8'h05, 8'h05, 8'h05, 8'hFF, 8'hFF, 8'h7F,
                                                 8'h80, 8'h80, 8'h00, 8'h01, 8'h01};
      set_dims(16'd3, 16'd4);
      set_gaps(3, 3);
      foreach (vals[i]) send_sample(vals[i], i == vals.size() - 1);
      // frame ending on a value change
      send_sample(8'h10, 1'b0);
      send_sample(8'h10, 1'b0);
      send_sample(8'hEF, 1'b1);
      drain_encoder();
   endtask

   // Run cap: a run of 256 equal values whose last element ends the frame
   // sends the full run of 255, then flushes a run of one.
   task automatic test_run_cap();
      set_dims(16'd1, 16'd256);
      set_gaps(0, 0);
      repeat (255) send_sample(8'hF9, 1'b0);
      send_sample(8'hF9, 1'b1);
      drain_encoder();
   endtask

   // Register write in the middle of a frame: the header already sent stays,
   // the next frame's header carries the new dimensions.
   task automatic test_midframe_config();
      set_dims(16'd10, 16'd10);
      set_gaps(2, 2);
      send_sample(8'h33, 1'b0);
      send_sample(8'h33, 1'b0);
      send_sample(8'h44, 1'b0);
      drain_encoder();
      set_dims(16'd20, 16'd30);
      send_sample(8'h44, 1'b0);
      send_sample(8'h55, 1'b1);
      send_sample(8'h66, 1'b1);
      drain_encoder();
   endtask

   // Hold the receiver off for a long stretch while the sender streams
   // run changes, so the encoder queue fills and stalls its input.
   task automatic test_backpressure();
      set_dims(16'h0102, 16'h0304);
      set_gaps(0, 0);
      hold_len <= 120;
      hold_seq <= hold_seq + 1;
      for (int i = 0; i < 20; i++) send_sample(8'(i * 37), i == 19);
      drain_encoder();
   endtask

   // Random frames built from runs of random values, with some pure noise,
   // new dimensions between some frames and random idling on both sides.
   task automatic test_random_frames();
      int sent;
      int flen;
      int rlen;
      logic [rbpe_pkg::ByteWidth-1:0] v;
      logic [rbpe_pkg::CountWidth-1:0] r;
      logic [rbpe_pkg::CountWidth-1:0] c;
      sent = 0;
      while (sent < RandomItems) begin
         if ($urandom_range(0, 2) == 0) begin
            // pause until everything has come, then reprogram
            drain_encoder();
            if ($urandom_range(0, 3) == 0) begin
               r = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
               c = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            end else begin
               r = 16'($urandom);
               c = 16'($urandom);
            end
            set_dims(r, c);
         end
         case ($urandom_range(0, 3))
            0: set_gaps(0, 0);
            1: set_gaps(14, 0);
            2: set_gaps(0, 14);
            default: set_gaps(14, 14);
         endcase
         flen = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 24);
         rlen = 0;
         for (int i = 0; i < flen; i++) begin
            if ($urandom_range(0, 7) == 0) begin
               v = 8'($urandom);
            end else if (rlen == 0) begin
               v    = 8'($urandom);
               rlen = $urandom_range(1, 6);
            end
            if (rlen > 0) rlen--;
            send_sample(v, i == flen - 1);
            sent++;
         end
      end
      drain_encoder();
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      reset               = 1'b1;
      req_if.valid        = 1'b0;
      req_if.sample_value = '0;
      req_if.frame_end    = 1'b0;
      csr_if.valid        = 1'b0;
      csr_if.index        = rbpe_pkg::RegRowCount;
      csr_if.data         = '0;
      // shadow state after reset
      dims_rows  = '0;
      dims_cols  = '0;
      run_val    = '0;
      run_len    = '0;
      frame_open = 1'b0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_single_element_frames();
      test_run_changes();
      test_run_cap();
      test_midframe_config();
      test_backpressure();
      test_random_frames();

      drain_encoder();
      repeat (SettleCycles) @(posedge clock);
      if (pending_bytes.size() != 0) begin
         $display("%0t ns: %0d expected bytes never arrived", $time, pending_bytes.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

FILE: sim.f
sv/rbpe_pkg.sv
sv/rbpe_ifs.sv
sv/rbpe_front.sv
sv/rbpe_queue.sv
sv/rbpe_back.sv
sv/rle_byte_pair_encoder.sv
verif/tb_top.sv
